FILE: design/ect_pkg.sv
package ect_pkg;

  // Longest stream whose positions are told apart; positions saturate beyond it.
  localparam int unsigned MAX_STREAM_LEN = 65536;
  localparam int unsigned POS_W  = 16;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned KIND_W = 4;
  localparam int unsigned POS_MAX_I =
    (MAX_STREAM_LEN - 1 > 65535) ? 65535 : MAX_STREAM_LEN - 1;
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(POS_MAX_I);

  // Up to three tokens leave for one character.
  localparam int unsigned MAX_TOK = 3;
  localparam int unsigned CNT_W   = $clog2(MAX_TOK + 1);

  // Depth of the queue between the scanner and the token sender.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_EQUALS = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_0      = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9      = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LA     = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LZ     = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_UA     = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UZ     = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_S      = 8'h73;
  localparam logic [CHAR_W-1:0] CH_I      = 8'h69;
  localparam logic [CHAR_W-1:0] CH_N      = 8'h6E;
  localparam logic [CHAR_W-1:0] CH_C      = 8'h63;
  localparam logic [CHAR_W-1:0] CH_O      = 8'h6F;
  localparam logic [CHAR_W-1:0] CH_T      = 8'h74;
  localparam logic [CHAR_W-1:0] CH_A      = 8'h61;
  localparam logic [CHAR_W-1:0] CH_X      = 8'h78;

  typedef enum logic [KIND_W-1:0] {
    K_LPAREN = 4'd0,
    K_RPAREN = 4'd1,
    K_ADD    = 4'd2,
    K_SUB    = 4'd3,
    K_MUL    = 4'd4,
    K_DIV    = 4'd5,
    K_EQ     = 4'd6,
    K_NUMBER = 4'd7,
    K_SIN    = 4'd8,
    K_COS    = 4'd9,
    K_TAN    = 4'd10,
    K_VAR    = 4'd11,
    K_IDENT  = 4'd12,
    K_END    = 4'd13,
    K_ERROR  = 4'd14
  } kind_t;

  typedef enum logic [2:0] {
    M_IDLE,
    M_INT,
    M_DOT,
    M_FRAC,
    M_WORD,
    M_SILENT
  } mode_t;

  typedef enum logic [2:0] {
    C_PUNCT,
    C_SPACE,
    C_DIGIT,
    C_ALPHA,
    C_OTHER
  } cls_t;

  typedef struct packed {
    kind_t             kind;
    logic [POS_W-1:0]  start;
    logic [POS_W-1:0]  len;
  } tok_t;

  // All tokens caused by one character, oldest in slot 0.
  typedef struct packed {
    logic [CNT_W-1:0]   count;
    tok_t [MAX_TOK-1:0] slot;
  } bundle_t;

  function automatic cls_t char_class(input logic [CHAR_W-1:0] c);
    cls_t cls;
    if (c == CH_LPAREN || c == CH_RPAREN || c == CH_PLUS || c == CH_MINUS ||
        c == CH_STAR || c == CH_SLASH || c == CH_EQUALS) begin
      cls = C_PUNCT;
    end else if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) begin
      cls = C_SPACE;
    end else if (c >= CH_0 && c <= CH_9) begin
      cls = C_DIGIT;
    end else if ((c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ)) begin
      cls = C_ALPHA;
    end else begin
      cls = C_OTHER;
    end
    return cls;
  endfunction

  function automatic kind_t punct_kind(input logic [CHAR_W-1:0] c);
    kind_t k;
    priority if (c == CH_LPAREN) k = K_LPAREN;
    else if (c == CH_RPAREN) k = K_RPAREN;
    else if (c == CH_PLUS)   k = K_ADD;
    else if (c == CH_MINUS)  k = K_SUB;
    else if (c == CH_STAR)   k = K_MUL;
    else if (c == CH_SLASH)  k = K_DIV;
    else                     k = K_EQ;
    return k;
  endfunction

  function automatic kind_t word_kind(input logic [2:0][CHAR_W-1:0] pre,
                                      input logic [2:0] wlen);
    kind_t k;
    k = K_IDENT;
    if (wlen == 3'd1 && pre[0] == CH_X) begin
      k = K_VAR;
    end else if (wlen == 3'd3) begin
      if (pre[0] == CH_S && pre[1] == CH_I && pre[2] == CH_N) k = K_SIN;
      else if (pre[0] == CH_C && pre[1] == CH_O && pre[2] == CH_S) k = K_COS;
      else if (pre[0] == CH_T && pre[1] == CH_A && pre[2] == CH_N) k = K_TAN;
    end
    return k;
  endfunction

  function automatic tok_t mk_tok(input kind_t k, input logic [POS_W-1:0] s,
                                  input logic [POS_W-1:0] l);
    tok_t t;
    t.kind  = k;
    t.start = s;
    t.len   = l;
    return t;
  endfunction

endpackage

FILE: design/ect_in_if.sv
interface ect_in_if;
  logic                      valid;
  logic                      ready;
  logic [ect_pkg::CHAR_W-1:0] char_code;
  logic                      end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

FILE: design/ect_out_if.sv
interface ect_out_if;
  logic                      valid;
  logic                      ready;
  logic [ect_pkg::KIND_W-1:0] token_kind;
  logic [ect_pkg::POS_W-1:0]  start_pos;
  logic [ect_pkg::POS_W-1:0]  token_len;
  logic                      run_last;

  modport source (output valid, output token_kind, output start_pos, output token_len,
                  output run_last, input ready);
  modport sink   (input valid, input token_kind, input start_pos, input token_len,
                  input run_last, output ready);
endinterface

FILE: design/ect_front.sv
module ect_front (
  input  logic             clk,
  input  logic             rst_n,
  ect_in_if.sink           in_chan,
  input  logic             q_full,
  output logic             q_push,
  output ect_pkg::bundle_t q_data
);
  import ect_pkg::*;

  mode_t                   mode_r, mode_scan;
  logic [POS_W-1:0]        start_r, start_scan;
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic [2:0][CHAR_W-1:0]  prefix_r, prefix_scan;
  logic [POS_W-1:0]        dot_r, dot_scan;
  logic [2:0]              wlen_r, wlen_scan;
  logic                    do_fresh;
  logic                    accept;
  logic [CHAR_W-1:0]       c;
  logic                    eot;
  cls_t                    cls;
  logic                    is_dig;
  logic                    is_alnum;
  bundle_t                 bundle;

  assign c        = in_chan.char_code;
  assign eot      = in_chan.end_of_text;
  assign cls      = char_class(c);
  assign is_dig   = (cls == C_DIGIT);
  assign is_alnum = (cls == C_DIGIT) || (cls == C_ALPHA);
  assign accept   = in_chan.valid && !q_full;
  assign pos_nxt  = (pos_r < POS_MAX) ? pos_r + 1'b1 : POS_MAX;

  assign in_chan.ready = !q_full;

  // Next scan state for this character, before the end-of-text reset.
  always_comb begin
    mode_scan   = mode_r;
    start_scan  = start_r;
    prefix_scan = prefix_r;
    dot_scan    = dot_r;
    wlen_scan   = wlen_r;
    do_fresh    = 1'b0;
    unique case (mode_r)
      M_IDLE: begin
        do_fresh = 1'b1;
      end
      M_INT: begin
        if (!is_dig) begin
          if (c == CH_DOT) begin
            mode_scan = M_DOT;
            dot_scan  = pos_r;
          end else begin
            do_fresh = 1'b1;
          end
        end
      end
      M_DOT: begin
        mode_scan = is_dig ? M_FRAC : M_SILENT;
      end
      M_FRAC: begin
        if (!is_dig) do_fresh = 1'b1;
      end
      M_WORD: begin
        if (is_alnum) begin
          if (wlen_r < 3'd3) prefix_scan[wlen_r[1:0]] = c;
          if (wlen_r < 3'd4) wlen_scan = wlen_r + 3'd1;
        end else begin
          do_fresh = 1'b1;
        end
      end
      default: begin
        mode_scan = M_SILENT;
      end
    endcase

    if (do_fresh) begin
      mode_scan = M_IDLE;
      unique case (cls)
        C_DIGIT: begin
          mode_scan  = M_INT;
          start_scan = pos_r;
        end
        C_ALPHA: begin
          mode_scan   = M_WORD;
          start_scan  = pos_r;
          prefix_scan = '0;
          prefix_scan[0] = c;
          wlen_scan   = 3'd1;
        end
        C_OTHER: begin
          mode_scan = M_SILENT;
        end
        default: begin
        end
      endcase
    end
  end

  // Tokens caused by this character, in the order they leave.
  always_comb begin
    logic [CNT_W:0] n;
    n = '0;
    bundle.slot = '0;

    unique case (mode_r)
      M_INT, M_FRAC: begin
        if (do_fresh) begin
          bundle.slot[n[CNT_W-1:0]] = mk_tok(K_NUMBER, start_r, pos_r - start_r);
          n = n + 1'b1;
        end
      end
      M_DOT: begin
        if (!is_dig) begin
          bundle.slot[n[CNT_W-1:0]] = mk_tok(K_NUMBER, start_r, dot_r - start_r);
          n = n + 1'b1;
          bundle.slot[n[CNT_W-1:0]] = mk_tok(K_ERROR, dot_r, POS_W'(1));
          n = n + 1'b1;
        end
      end
      M_WORD: begin
        if (do_fresh) begin
          bundle.slot[n[CNT_W-1:0]] =
            mk_tok(word_kind(prefix_r, wlen_r), start_r, pos_r - start_r);
          n = n + 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (do_fresh && cls == C_PUNCT) begin
      bundle.slot[n[CNT_W-1:0]] = mk_tok(punct_kind(c), pos_r, POS_W'(1));
      n = n + 1'b1;
    end else if (do_fresh && cls == C_OTHER) begin
      bundle.slot[n[CNT_W-1:0]] = mk_tok(K_ERROR, pos_r, POS_W'(1));
      n = n + 1'b1;
    end

    if (eot) begin
      unique case (mode_scan)
        M_INT, M_FRAC: begin
          bundle.slot[n[CNT_W-1:0]] = mk_tok(K_NUMBER, start_scan, pos_nxt - start_scan);
          n = n + 1'b1;
        end
        M_DOT: begin
          bundle.slot[n[CNT_W-1:0]] = mk_tok(K_NUMBER, start_scan, dot_scan - start_scan);
          n = n + 1'b1;
          bundle.slot[n[CNT_W-1:0]] = mk_tok(K_ERROR, dot_scan, POS_W'(1));
          n = n + 1'b1;
        end
        M_WORD: begin
          bundle.slot[n[CNT_W-1:0]] =
            mk_tok(word_kind(prefix_scan, wlen_scan), start_scan, pos_nxt - start_scan);
          n = n + 1'b1;
        end
        default: begin
        end
      endcase
      bundle.slot[n[CNT_W-1:0]] = mk_tok(K_END, pos_nxt, '0);
      n = n + 1'b1;
    end

    bundle.count = n[CNT_W-1:0];
  end

  assign q_push = accept && (bundle.count != '0);
  assign q_data = bundle;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      pos_r  <= '0;
      wlen_r <= '0;
    end else if (accept) begin
      if (eot) begin
        mode_r <= M_IDLE;
        pos_r  <= '0;
        wlen_r <= '0;
      end else begin
        mode_r <= mode_scan;
        pos_r  <= pos_nxt;
        wlen_r <= wlen_scan;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      start_r  <= start_scan;
      prefix_r <= prefix_scan;
      dot_r    <= dot_scan;
    end
  end

endmodule

FILE: design/ect_queue.sv
module ect_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ect_pkg::bundle_t wdata,
  output logic             full,
  input  logic             pop,
  output ect_pkg::bundle_t rdata,
  output logic             empty
);
  import ect_pkg::*;

  bundle_t           mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push;
  logic              do_pop;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wdata;
  end

endmodule

FILE: design/ect_back.sv
module ect_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  ect_pkg::bundle_t q_head,
  output logic             q_pop,
  ect_out_if.source        out_chan
);
  import ect_pkg::*;

  logic             out_valid_r;
  tok_t             tok_r;
  logic             last_r;
  logic [CNT_W-1:0] idx_r;
  logic             load;
  logic             head_last;

  assign load      = !q_empty && (!out_valid_r || out_chan.ready);
  assign head_last = (idx_r == q_head.count - 1'b1);
  assign q_pop     = load && head_last;

  assign out_chan.valid      = out_valid_r;
  assign out_chan.token_kind = tok_r.kind;
  assign out_chan.start_pos  = tok_r.start;
  assign out_chan.token_len  = tok_r.len;
  assign out_chan.run_last   = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r       <= head_last ? '0 : idx_r + 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tok_r  <= q_head.slot[idx_r];
      last_r <= head_last;
    end
  end

endmodule

FILE: design/expression_char_tokenizer.sv
// Streaming lexer for arithmetic expressions. One ASCII character is taken per
// request on in_chan, with end_of_text marking the last character of a stream;
// tokens leave on out_chan as kind, start position and length, and run_last
// flags the final token caused by a character. Characters are taken at one per
// clock as long as the token queue has room; the character scanner finishes
// each character in the cycle it is taken. The output sends one token per clock
// while the receiver is ready, so a character that causes two or three tokens
// (a number closed by an operator, a dot with no digit after it, or the last
// character of a stream with a token open) keeps the output busy for longer,
// and a long run of such characters fills the four-entry queue and then slows
// the input to the output rate. The first token of a character leaves via
// the queue and the output register. Whitespace, and characters inside a
// number or an identifier, cause no token. After an unexpected character the
// stream is silent until its end token; every stream ends with an end token,
// after which the scanner starts the next stream at position zero.
module expression_char_tokenizer (
  input  logic      clk,
  input  logic      rst_n,
  ect_in_if.sink    in_chan,
  ect_out_if.source out_chan
);
  import ect_pkg::*;

  // The scanner hands all tokens of one character to the queue as a bundle.
  logic    q_full;
  logic    q_push;
  bundle_t q_wdata;

  // The sender drains the head bundle one token at a time.
  logic    q_empty;
  logic    q_pop;
  bundle_t q_head;

  // Scanner: classifies each character, keeps the scan state and builds the
  // tokens the character closes or opens.
  ect_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_wdata)
  );

  // Queue of token bundles so that the scanner and the sender stall apart.
  ect_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_head),
    .empty (q_empty)
  );

  // Sender: registered output stage, one token per request.
  ect_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule

FILE: tb/sv/expression_char_tokenizer_checker.sv
`timescale 1ns / 100ps

module expression_char_tokenizer_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [ect_pkg::CHAR_W-1:0] in_char_code,
  input  logic                       in_end_of_text,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [ect_pkg::KIND_W-1:0] out_token_kind,
  input  logic [ect_pkg::POS_W-1:0]  out_start_pos,
  input  logic [ect_pkg::POS_W-1:0]  out_token_len,
  input  logic                       out_run_last,
  output int unsigned                mismatches,
  output int unsigned                outstanding
);
  import ect_pkg::*;

  typedef struct {
    kind_t            kind;
    logic [POS_W-1:0] start;
    logic [POS_W-1:0] len;
    logic             last;
  } token_exp_t;

  token_exp_t expected_tokens[$];

  // Scanner state, kept apart from the block's own registers.
  mode_t             scan_mode;
  logic [POS_W-1:0]  tok_start;
  logic [POS_W-1:0]  cur_pos;
  logic [POS_W-1:0]  dot_at;
  logic [CHAR_W-1:0] prefix [3];
  logic [2:0]        word_len;

  function automatic bit is_digit_char(input logic [CHAR_W-1:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  function automatic bit is_letter(input logic [CHAR_W-1:0] c);
    return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
  endfunction

  function automatic void clear_scanner();
    scan_mode = M_IDLE;
    tok_start = '0;
    cur_pos   = '0;
    dot_at    = '0;
    prefix[0] = '0;
    prefix[1] = '0;
    prefix[2] = '0;
    word_len  = '0;
  endfunction

  function automatic void push_token(input kind_t k, input logic [POS_W-1:0] s,
                                     input logic [POS_W-1:0] l);
    token_exp_t t;
    t.kind  = k;
    t.start = s;
    t.len   = l;
    t.last  = 1'b0;
    expected_tokens.push_back(t);
  endfunction

  function automatic kind_t word_token_kind();
    kind_t k;
    k = K_IDENT;
    if (word_len == 3'd1 && prefix[0] == CH_X) begin
      k = K_VAR;
    end else if (word_len == 3'd3) begin
      if (prefix[0] == CH_S && prefix[1] == CH_I && prefix[2] == CH_N) k = K_SIN;
      else if (prefix[0] == CH_C && prefix[1] == CH_O && prefix[2] == CH_S) k = K_COS;
      else if (prefix[0] == CH_T && prefix[1] == CH_A && prefix[2] == CH_N) k = K_TAN;
    end
    return k;
  endfunction

  // A character seen with no token open.
  function automatic void open_token(input logic [CHAR_W-1:0] c, input logic [POS_W-1:0] p);
    scan_mode = M_IDLE;
    case (c)
      CH_LPAREN: push_token(K_LPAREN, p, 16'd1);
      CH_RPAREN: push_token(K_RPAREN, p, 16'd1);
      CH_PLUS:   push_token(K_ADD, p, 16'd1);
      CH_MINUS:  push_token(K_SUB, p, 16'd1);
      CH_STAR:   push_token(K_MUL, p, 16'd1);
      CH_SLASH:  push_token(K_DIV, p, 16'd1);
      CH_EQUALS: push_token(K_EQ, p, 16'd1);
      CH_SPACE, CH_TAB, CH_CR, CH_LF: ;
      default: begin
        if (is_digit_char(c)) begin
          scan_mode = M_INT;
          tok_start = p;
        end else if (is_letter(c)) begin
          scan_mode = M_WORD;
          tok_start = p;
          prefix[0] = c;
          prefix[1] = '0;
          prefix[2] = '0;
          word_len  = 3'd1;
        end else begin
          push_token(K_ERROR, p, 16'd1);
          scan_mode = M_SILENT;
        end
      end
    endcase
  endfunction

  function automatic void tokenize_char(input logic [CHAR_W-1:0] c, input logic eot);
    logic [POS_W-1:0] p;
    logic [POS_W-1:0] nxt;
    int               n_before;
    p        = cur_pos;
    nxt      = (p < POS_MAX) ? p + 1'b1 : POS_MAX;
    n_before = expected_tokens.size();
    case (scan_mode)
      M_IDLE: open_token(c, p);
      M_INT, M_FRAC: begin
        if (is_digit_char(c)) begin
        end else if (scan_mode == M_INT && c == CH_DOT) begin
          scan_mode = M_DOT;
          dot_at    = p;
        end else begin
          push_token(K_NUMBER, tok_start, p - tok_start);
          open_token(c, p);
        end
      end
      M_DOT: begin
        if (is_digit_char(c)) begin
          scan_mode = M_FRAC;
        end else begin
          push_token(K_NUMBER, tok_start, dot_at - tok_start);
          push_token(K_ERROR, dot_at, 16'd1);
          scan_mode = M_SILENT;
        end
      end
      M_WORD: begin
        if (is_digit_char(c) || is_letter(c)) begin
          if (word_len < 3'd3) prefix[word_len] = c;
          if (word_len < 3'd4) word_len = word_len + 3'd1;
        end else begin
          push_token(word_token_kind(), tok_start, p - tok_start);
          open_token(c, p);
        end
      end
      default: scan_mode = M_SILENT;
    endcase

    if (eot) begin
      if (scan_mode == M_INT || scan_mode == M_FRAC) begin
        push_token(K_NUMBER, tok_start, nxt - tok_start);
      end else if (scan_mode == M_DOT) begin
        push_token(K_NUMBER, tok_start, dot_at - tok_start);
        push_token(K_ERROR, dot_at, 16'd1);
      end else if (scan_mode == M_WORD) begin
        push_token(word_token_kind(), tok_start, nxt - tok_start);
      end
      push_token(K_END, nxt, 16'd0);
      clear_scanner();
    end else begin
      cur_pos = nxt;
    end

    if (expected_tokens.size() > n_before)
      expected_tokens[expected_tokens.size() - 1].last = 1'b1;
  endfunction

  // Tokens are checked before the character of the same edge is scanned, since
  // no token can leave in the cycle its character is taken.
  always @(posedge clk) begin
    token_exp_t want;
    if (!rst_n) begin
      clear_scanner();
      expected_tokens.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_tokens.size() == 0) begin
          $error("unexpected token: token_kind %0d start_pos %0d token_len %0d",
                 out_token_kind, out_start_pos, out_token_len);
          mismatches++;
        end else begin
          want = expected_tokens.pop_front();
          if (out_token_kind !== want.kind) begin
            $error("token_kind: expected %0d, got %0d", want.kind, out_token_kind);
            mismatches++;
          end
          if (out_start_pos !== want.start) begin
            $error("start_pos: expected %0d, got %0d", want.start, out_start_pos);
            mismatches++;
          end
          if (out_token_len !== want.len) begin
            $error("token_len: expected %0d, got %0d", want.len, out_token_len);
            mismatches++;
          end
          if (out_run_last !== want.last) begin
            $error("run_last: expected %0d, got %0d", want.last, out_run_last);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) tokenize_char(in_char_code, in_end_of_text);
    end
    outstanding <= expected_tokens.size();
  end

endmodule

FILE: tb/sv/expression_char_tokenizer_tb.sv
`timescale 1ns / 100ps

// Top of the lexer testbench. This module only makes stimulus and gives the
// verdict: the checker beside the block watches both channels, predicts the
// tokens of every accepted character and compares them as they leave.
module expression_char_tokenizer_tb;
  import ect_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 3;
  // Characters of random expression text to send after the directed part.
  localparam int RANDOM_CHARS = 100;
  // Longest random wait of each side before a request when idling is on.
  localparam int MAX_GAP      = 9;
  // A long receiver hold-off, long enough to fill the token queue.
  localparam int LONG_HOLD    = 60;
  // Wait after the last expected token, long enough to catch stray tokens.
  localparam int DRAIN_CYCLES = 10;
  // Watchdog limit for the whole run, well above the slowest correct run.
  localparam int unsigned CYCLE_LIMIT = 50000;

  logic clk;
  logic rst_n;

  ect_in_if  in_chan ();
  ect_out_if out_chan ();

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned cycle_count = 0;

  // Idling switches, set by the stimulus per phase and per stream.
  bit src_idle_on;
  bit snk_idle_on;
  // The stimulus asks for a long hold-off by bumping the first counter; the
  // receiver serves it and bumps the second.
  int unsigned long_holds_asked;
  int unsigned long_holds_done;

  logic [CHAR_W-1:0] stream_text[$];
  int unsigned       random_chars_sent;

  expression_char_tokenizer uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  expression_char_tokenizer_checker token_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_chan.valid),
    .in_ready       (in_chan.ready),
    .in_char_code   (in_chan.char_code),
    .in_end_of_text (in_chan.end_of_text),
    .out_valid      (out_chan.valid),
    .out_ready      (out_chan.ready),
    .out_token_kind (out_chan.token_kind),
    .out_start_pos  (out_chan.start_pos),
    .out_token_len  (out_chan.token_len),
    .out_run_last   (out_chan.run_last),
    .mismatches     (mismatches),
    .outstanding    (outstanding)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // Watchdog: a hung handshake or a lost token ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("expression_char_tokenizer_tb: FAIL");
      $finish;
    end
  end

  // Token receiver. For every request it first draws a stall, then holds
  // ready high until a token is taken. A pending long hold-off replaces the
  // drawn stall once.
  initial begin : token_receiver
    int gap;
    out_chan.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_holds_asked != long_holds_done) begin
        gap = LONG_HOLD;
        long_holds_done++;
      end else begin
        gap = snk_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (gap > 0) begin
        out_chan.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      @(posedge clk);
      while (!(out_chan.valid && out_chan.ready)) @(posedge clk);
    end
  end

  // Offer one character and return at the edge where the request is taken.
  // When no gap is drawn, valid simply stays high into the next request.
  task automatic send_char(input logic [CHAR_W-1:0] c, input logic eot);
    int gap;
    gap = src_idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.char_code   <= c;
    in_chan.end_of_text <= eot;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  task automatic send_text(input string s, input bit eot_last);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], eot_last && (i == s.len() - 1));
  endtask

  function automatic logic [CHAR_W-1:0] rand_digit();
    return CH_0 + CHAR_W'($urandom_range(0, 9));
  endfunction

  function automatic logic [CHAR_W-1:0] rand_letter();
    if ($urandom_range(0, 1) == 0) return CH_LA + CHAR_W'($urandom_range(0, 25));
    return CH_UA + CHAR_W'($urandom_range(0, 25));
  endfunction

  function automatic logic [CHAR_W-1:0] rand_operator();
    logic [CHAR_W-1:0] c;
    case ($urandom_range(0, 6))
      0:       c = CH_LPAREN;
      1:       c = CH_RPAREN;
      2:       c = CH_PLUS;
      3:       c = CH_MINUS;
      4:       c = CH_STAR;
      5:       c = CH_SLASH;
      default: c = CH_EQUALS;
    endcase
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] rand_blank();
    logic [CHAR_W-1:0] c;
    case ($urandom_range(0, 3))
      0:       c = CH_SPACE;
      1:       c = CH_TAB;
      2:       c = CH_CR;
      default: c = CH_LF;
    endcase
    return c;
  endfunction

  function automatic void append_text(input string s);
    for (int i = 0; i < s.len(); i++) stream_text.push_back(s[i]);
  endfunction

  function automatic void append_digits(input int lo, input int hi);
    repeat ($urandom_range(lo, hi)) stream_text.push_back(rand_digit());
  endfunction

  // Build one stream of expression text from random pieces. Most pieces are
  // well formed (numbers, words, keywords, operators, blanks); roughly one in
  // seven is noise: a stray byte, a dot followed by a non-digit, or a number
  // ending in a bare dot.
  function automatic void compose_stream();
    int sel;
    stream_text.delete();
    repeat ($urandom_range(1, 8)) begin
      sel = $urandom_range(0, 19);
      if (sel < 5) begin
        append_digits(1, 4);
        if ($urandom_range(0, 2) == 0) begin
          stream_text.push_back(CH_DOT);
          append_digits(1, 3);
        end
      end else if (sel < 9) begin
        case ($urandom_range(0, 5))
          0: append_text("sin");
          1: append_text("cos");
          2: append_text("tan");
          3: append_text("x");
          default: begin
            stream_text.push_back(rand_letter());
            repeat ($urandom_range(0, 4))
              stream_text.push_back(($urandom_range(0, 2) == 0) ? rand_digit() : rand_letter());
          end
        endcase
      end else if (sel < 14) begin
        stream_text.push_back(rand_operator());
      end else if (sel < 17) begin
        repeat ($urandom_range(1, 2)) stream_text.push_back(rand_blank());
      end else if (sel == 17) begin
        append_digits(1, 3);
        stream_text.push_back(CH_DOT);
        stream_text.push_back(rand_operator());
      end else if (sel == 18) begin
        stream_text.push_back(CHAR_W'($urandom_range(0, 255)));
      end else begin
        append_digits(1, 3);
        stream_text.push_back(CH_DOT);
      end
    end
  endfunction

  initial begin : stimulus
    in_chan.valid       = 1'b0;
    in_chan.char_code   = '0;
    in_chan.end_of_text = 1'b0;
    rst_n               = 1'b0;
    src_idle_on         = 1'b1;
    snk_idle_on         = 1'b1;
    long_holds_asked    = 0;
    random_chars_sent   = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed streams, both sides idling.
    // Keyword, parentheses, the variable, a product, and a fraction closed by
    // the end of the stream.
    send_text("sin(x)*2.5", 1'b1);
    // Equals, then a number whose dot is still waiting for a digit at the end:
    // the number, an error for the dot, then the end token.
    send_text("=7.", 1'b1);
    // A dot followed by an operator: number and error, then the rest of the
    // stream is silent until its end token.
    send_text("1.+c", 1'b1);
    // Every bit of the character set and cleared: two unexpected codes, the
    // second one arriving on an already silenced stream.
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b1);
    // Tab, CR and LF blanks around words, an upper-case identifier with a
    // digit, and the remaining operators.
    send_char(CH_TAB, 1'b0);
    send_text("cos+Zz0-", 1'b0);
    send_char(CH_CR, 1'b0);
    send_char(CH_SLASH, 1'b0);
    send_char(CH_LF, 1'b1);

    // Back pressure: the receiver holds off for a long stretch while the
    // sender keeps offering digit-operator pairs back to back, each closing a
    // number and adding an operator token. The token queue fills and the
    // input stalls.
    src_idle_on = 1'b0;
    snk_idle_on = 1'b1;
    long_holds_asked++;
    for (int i = 0; i < 12; i++) begin
      send_char(rand_digit(), 1'b0);
      send_char(CH_PLUS, i == 11);
    end

    // Random expression streams. Each stream draws its own idling mix, and
    // now and then the receiver is asked for another long hold-off.
    while (random_chars_sent < RANDOM_CHARS) begin
      case ($urandom_range(0, 5))
        0: begin
          src_idle_on = 1'b0;
          snk_idle_on = 1'b0;
        end
        1: begin
          src_idle_on = 1'b0;
          snk_idle_on = 1'b1;
        end
        2: begin
          src_idle_on = 1'b1;
          snk_idle_on = 1'b0;
        end
        default: begin
          src_idle_on = 1'b1;
          snk_idle_on = 1'b1;
        end
      endcase
      if ($urandom_range(0, 9) == 0) long_holds_asked++;
      compose_stream();
      for (int i = 0; i < stream_text.size(); i++)
        send_char(stream_text[i], i == stream_text.size() - 1);
      random_chars_sent += stream_text.size();
    end

    in_chan.valid <= 1'b0;
    // The checker publishes its backlog through a register, so step past the
    // last request before reading it.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("expression_char_tokenizer_tb: PASS");
    end else begin
      $display("expression_char_tokenizer_tb: FAIL");
    end
    $finish;
  end

endmodule
